// File: design/ccf_pkg.sv
// ----------------------------------------------------------------------------
// ccf_pkg
// Shared types, constants and packet helpers for the CAN command framer.
// ----------------------------------------------------------------------------
package ccf_pkg;

	// Table geometry
	localparam int TABLE_ENTRIES = 16;
	localparam int MAX_OUT       = 16;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W         = $clog2(MAX_OUT + 1);
	localparam int ID_W          = 29;
	localparam int PAY_W         = 64;

	// Packet constants
	localparam logic [7:0] HDR_SYNC0  = 8'h55;
	localparam logic [7:0] HDR_SYNC1  = 8'hAA;
	localparam logic [7:0] HDR_LEN    = 8'h1E;
	localparam logic [7:0] HDR_TYPE   = 8'h03;
	localparam logic [7:0] HDR_CMD    = 8'h01;
	localparam logic [7:0] HDR_BYTE8  = 8'h0A;
	localparam logic [7:0] HDR_BYTE18 = 8'h08;
	localparam logic [7:0] TOP_LO     = 8'hFB;
	localparam logic [7:0] TOP_HI     = 8'hFD;
	localparam logic [7:0] FILL_BYTE  = 8'hFF;

	// Request and packet payloads
	typedef struct packed {
		logic             func;
		logic [ID_W-1:0]  frame_id;
		logic [PAY_W-1:0] frame_payload;
	} ccf_req_t;

	typedef struct packed {
		logic [63:0] packet_bytes_0_7;
		logic [63:0] packet_bytes_8_15;
		logic [63:0] packet_bytes_16_23;
		logic [47:0] packet_bytes_24_29;
		logic        is_repeat;
		logic        latch_dropped;
		logic        last;
	} ccf_pkt_t;

	// Request kinds
	localparam logic FUNC_FRAME = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FR_SCAN,
		ST_FR_DONE,
		ST_TK_SCAN,
		ST_TK_DONE,
		ST_TK_LOAD,
		ST_TK_LAST
	} ccf_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic scan_start;
		logic fr_commit;
		logic tk_emit;
		logic emit_last;
		logic tk_promote;
		logic tk_load;
	} ccf_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_done;
		logic best;
		logic pend_v;
		logic pcnt_full;
		logic out_free;
	} ccf_sts_t;

	// Replace the lower seven data bytes with the fill pattern when the last byte is a special code
	function automatic logic [PAY_W-1:0] shape_payload(input logic [PAY_W-1:0] data);
		logic [7:0] top;
		top = data[63:56];
		if (top >= TOP_LO && top <= TOP_HI) begin
			return {top, {7{FILL_BYTE}}};
		end
		return data;
	endfunction

	// Assemble one 30-byte packet
	function automatic ccf_pkt_t build_packet(
		input logic [ID_W-1:0]  id,
		input logic [PAY_W-1:0] pay,
		input logic             rep,
		input logic             drop,
		input logic             fin
	);
		ccf_pkt_t p;
		p.packet_bytes_0_7   = {24'h0, HDR_CMD, HDR_TYPE, HDR_LEN, HDR_SYNC1, HDR_SYNC0};
		p.packet_bytes_8_15  = {8'h00, id[15:0], 32'h0, HDR_BYTE8};
		p.packet_bytes_16_23 = {pay[23:0], 16'h0, HDR_BYTE18, 16'h0};
		p.packet_bytes_24_29 = {8'h00, pay[63:24]};
		p.is_repeat          = rep;
		p.latch_dropped      = drop;
		p.last               = fin;
		return p;
	endfunction

endpackage

// File: design/ccf_dpath.sv
// ----------------------------------------------------------------------------
// ccf_dpath
// Latch table memories, slot scan pipeline, pending repeat register and
// output packet register.
// ----------------------------------------------------------------------------
module ccf_dpath import ccf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ccf_req_t req,
	input  ccf_cmd_t cmd,
	output ccf_sts_t sts,
	output logic     pkt_valid,
	input  logic     pkt_ready,
	output ccf_pkt_t pkt
);

	// Table storage
	logic [ID_W-1:0]          id_mem  [TABLE_ENTRIES];
	logic [PAY_W-1:0]         pay_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	// Captured request
	logic [ID_W-1:0]  key_q;
	logic [PAY_W-1:0] pay_q;

	// Scan issue and evaluate stages
	logic [IDX_W-1:0] idx_q;
	logic             issue_q;
	logic             scan_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [ID_W-1:0]  id_s1;
	logic             vld_s1;

	// Scan results
	logic             done_q;
	logic             hit_q;
	logic             free_q;
	logic             best_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [ID_W-1:0]  best_id_q;

	// Pending repeat packet
	logic             pend_v_q;
	logic [ID_W-1:0]  pend_id_q;
	logic [PAY_W-1:0] pend_pay_q;
	logic [PAY_W-1:0] pay_rd_q;
	logic [CNT_W-1:0] pcnt_q;

	// Output register
	logic     pkt_valid_q;
	ccf_pkt_t pkt_q;

	logic             out_free;
	logic             last_elem;
	logic             is_match;
	logic             is_free;
	logic             is_cand;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;

	// Evaluate the slot in stage one
	always_comb begin
		out_free  = !pkt_valid_q || pkt_ready;
		last_elem = scan_s1 && (idx_s1 == IDX_W'(TABLE_ENTRIES - 1));
		is_match  = scan_s1 && vld_s1 && (id_s1 == key_q);
		is_free   = scan_s1 && !vld_s1;
		is_cand   = scan_s1 && vld_s1 && (!pend_v_q || id_s1 > pend_id_q) &&
			(!best_q || id_s1 < best_id_q);
		wr_en     = cmd.fr_commit && (hit_q || free_q);
		wr_idx    = hit_q ? hit_idx_q : free_idx_q;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			idx_q       <= '0;
			issue_q     <= 1'b0;
			scan_s1     <= 1'b0;
			done_q      <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			best_q      <= 1'b0;
			pend_v_q    <= 1'b0;
			pcnt_q      <= '0;
			pkt_valid_q <= 1'b0;
		end else begin
			scan_s1 <= issue_q;
			if (cmd.scan_start) begin
				idx_q   <= '0;
				issue_q <= 1'b1;
				done_q  <= 1'b0;
				hit_q   <= 1'b0;
				free_q  <= 1'b0;
				best_q  <= 1'b0;
			end else begin
				if (issue_q) begin
					if (idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						issue_q <= 1'b0;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				if (is_match) begin
					hit_q <= 1'b1;
				end
				if (is_free) begin
					free_q <= 1'b1;
				end
				if (is_cand) begin
					best_q <= 1'b1;
				end
				if (last_elem) begin
					done_q <= 1'b1;
				end
			end
			// Mark a newly latched slot
			if (wr_en && !hit_q) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (cmd.capture) begin
				pend_v_q <= 1'b0;
				pcnt_q   <= '0;
			end else if (cmd.tk_promote) begin
				pend_v_q <= 1'b1;
				pcnt_q   <= pcnt_q + CNT_W'(1);
			end
			if (cmd.fr_commit || cmd.tk_emit) begin
				pkt_valid_q <= 1'b1;
			end else if (pkt_ready) begin
				pkt_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers and table memories
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q <= req.frame_id;
			pay_q <= shape_payload(req.frame_payload);
		end
		idx_s1 <= idx_q;
		id_s1  <= id_mem[idx_q];
		vld_s1 <= valid_q[idx_q];
		if (is_match && !hit_q) begin
			hit_idx_q <= idx_s1;
		end
		if (is_free && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (is_cand) begin
			best_idx_q <= idx_s1;
			best_id_q  <= id_s1;
		end
		if (wr_en) begin
			pay_mem[wr_idx] <= pay_q;
			if (!hit_q) begin
				id_mem[free_idx_q] <= key_q;
			end
		end
		pay_rd_q <= pay_mem[best_idx_q];
		if (cmd.tk_promote) begin
			pend_id_q <= best_id_q;
		end
		if (cmd.tk_load) begin
			pend_pay_q <= pay_rd_q;
		end
		if (cmd.fr_commit) begin
			pkt_q <= build_packet(key_q, pay_q, 1'b0, !hit_q && !free_q, 1'b1);
		end else if (cmd.tk_emit) begin
			pkt_q <= build_packet(pend_id_q, pend_pay_q, 1'b1, 1'b0, cmd.emit_last);
		end
	end

	// Report status
	always_comb begin
		sts.scan_done = done_q;
		sts.best      = best_q;
		sts.pend_v    = pend_v_q;
		sts.pcnt_full = (pcnt_q == CNT_W'(MAX_OUT));
		sts.out_free  = out_free;
	end

	assign pkt_valid = pkt_valid_q;
	assign pkt       = pkt_q;

endmodule

// File: design/ccf_ctrl.sv
// ----------------------------------------------------------------------------
// ccf_ctrl
// Sequencer for frame latching and tick repeat: starts slot scans, commits
// table writes and hands packets to the output register.
// ----------------------------------------------------------------------------
module ccf_ctrl import ccf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_func,
	output logic     req_ready,
	input  ccf_sts_t sts,
	output ccf_cmd_t cmd
);

	ccf_state_t state_q;
	ccf_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture    = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = (req_func == FUNC_TICK) ? ST_TK_SCAN : ST_FR_SCAN;
				end
			end
			ST_FR_SCAN: begin
				if (sts.scan_done) begin
					state_d = ST_FR_DONE;
				end
			end
			ST_FR_DONE: begin
				// Latch and send the frame packet together
				if (sts.out_free) begin
					cmd.fr_commit = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_TK_SCAN: begin
				if (sts.scan_done) begin
					state_d = ST_TK_DONE;
				end
			end
			ST_TK_DONE: begin
				if (sts.best) begin
					// Another slot follows: release the pending one, advance
					if (!sts.pend_v) begin
						cmd.tk_promote = 1'b1;
						state_d        = ST_TK_LOAD;
					end else if (sts.out_free) begin
						cmd.tk_emit    = 1'b1;
						cmd.tk_promote = 1'b1;
						state_d        = ST_TK_LOAD;
					end
				end else if (!sts.pend_v) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.tk_emit   = 1'b1;
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_TK_LOAD: begin
				cmd.tk_load = 1'b1;
				if (sts.pcnt_full) begin
					state_d = ST_TK_LAST;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = ST_TK_SCAN;
				end
			end
			ST_TK_LAST: begin
				if (sts.out_free) begin
					cmd.tk_emit   = 1'b1;
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: design/can_command_framer_with_latch_repeat.sv
// ----------------------------------------------------------------------------
// can_command_framer_with_latch_repeat
// Builds 30-byte serial packets from CAN frames, latches them per identifier
// and re-emits every latched packet in ascending identifier order on a tick.
// ----------------------------------------------------------------------------
// A frame request (func = 0) produces one packet, marked last, after a scan of
// all TABLE_ENTRIES slots, once the output register is free. A tick request
// (func = 1) finds each next packet by a full slot scan that looks for the
// smallest identifier above the previous one, and an empty table gives no
// packet after one scan. At most MAX_OUT packets follow one tick. The table
// memory is scanned one slot per cycle through a single read port. A new
// request is taken only when the previous one is finished, while its final
// packet may still wait in the output register. The table comes out of reset
// empty; no clearing pass runs.
// ----------------------------------------------------------------------------
module can_command_framer_with_latch_repeat import ccf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  ccf_req_t req,
	output logic     pkt_valid,
	input  logic     pkt_ready,
	output ccf_pkt_t pkt
);

	ccf_cmd_t cmd;
	ccf_sts_t sts;

	// Sequencer
	ccf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_func  (req.func),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Table and packet datapath
	ccf_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt)
	);

	// A frame packet is always the only and final packet of its request
	assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && !pkt.is_repeat |-> pkt.last)
		else $error("frame packet without last");

	// Repeat packets never report a dropped latch
	assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && pkt.is_repeat |-> !pkt.latch_dropped)
		else $error("repeat packet flagged as dropped");

	// An accepted request blocks the next one in the following cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	// A packet is loaded only into a free output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fr_commit || cmd.tk_emit) |-> (!pkt_valid || pkt_ready))
		else $error("output register overwritten");

endmodule
